// ===== sv/point_cluster_by_distance_defines.svh =====
// Assertion macros for the file that checks the cluster block.
// Every check is sampled on the rising edge of aclk and is off while
// aresetn is low.
`ifndef POINT_CLUSTER_BY_DISTANCE_DEFINES_SVH
`define POINT_CLUSTER_BY_DISTANCE_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define PCD_ASSERT_NOW(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (prop)) \
        else $error(msg);

// Property that must hold in the cycle after its trigger.
`define PCD_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/pcd_pkg.sv =====
package pcd_pkg;

    // Capacity of the point store.
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Input word layout.
    localparam int COORD_W  = 16;
    localparam int RAD_W    = 16;
    localparam int XYR_W    = 2 * COORD_W + RAD_W;
    localparam int S_DATA_W = 48;

    // Arithmetic widths: difference, its square, sum of squares, link
    // distance and its square.
    localparam int DIST_W = 16;
    localparam int DX_W   = COORD_W + 1;
    localparam int SQ_W   = 2 * COORD_W;
    localparam int D2_W   = SQ_W + 1;
    localparam int TD_W   = DIST_W + 2;
    localparam int TD2_W  = 2 * TD_W;

    // Output word layout.
    localparam int OUT_IDX_W = 6;
    localparam int OUT_LBL_W = 6;
    localparam int OUT_CNT_W = 7;
    localparam int M_USED_W  = 2 * OUT_IDX_W + 2 * OUT_CNT_W;
    localparam int M_DATA_W  = 32;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [DIST_W-1:0] LINK_DISTANCE_RESET = DIST_W'(16);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LINK_DISTANCE = 2'd0,
        REG_USE_RADII     = 2'd1
    } cfg_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the word on the input channel
        logic scan_step;  // advance the compare pipeline by one step
        logic rel_step;   // one step of the relabel sweep
        logic finish;     // settle and store the new point's label
        logic out_issue;  // read the label of the next readout entry
        logic out_load;   // load the output register
    } pcd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;       // store holds MAX_POINTS points
        logic merge;      // compare stage found a link to another label
        logic scan_done;  // all earlier points compared, pipeline empty
        logic rel_done;   // relabel sweep complete
        logic last;       // the point being handled closes the set
        logic out_busy;   // output register still holds a word
        logic out_last;   // readout pointer is at the final point
    } pcd_sts_t;

endpackage

// ===== sv/pcd_ram.sv =====
module pcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pcd_ctrl.sv =====
module pcd_ctrl import pcd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    input  pcd_sts_t sts,
    output pcd_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_REL    = 6'b000100,
        S_FINISH = 6'b001000,
        S_OUT_RD = 6'b010000,
        S_OUT_LD = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.full) begin
                        state_next = s_tlast ? S_OUT_RD : S_IDLE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.merge) begin
                    state_next = S_REL;
                end else if (sts.scan_done) begin
                    state_next = S_FINISH;
                end
            end
            S_REL: begin
                if (sts.rel_done) begin
                    state_next = S_SCAN;
                end else begin
                    cmd.rel_step = 1'b1;
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = sts.last ? S_OUT_RD : S_IDLE;
            end
            S_OUT_RD: begin
                if (!sts.out_busy) begin
                    cmd.out_issue = 1'b1;
                    state_next    = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                cmd.out_load = 1'b1;
                state_next   = sts.out_last ? S_IDLE : S_OUT_RD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ===== sv/pcd_datapath.sv =====
module pcd_datapath import pcd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser,
    input  pcd_cmd_t              cmd,
    output pcd_sts_t              sts
);

    // Control registers.
    logic [DIST_W-1:0] link_dist_reg, link_dist_next;
    logic              use_radii_reg, use_radii_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  lbl_cnt_reg, lbl_cnt_next;
    logic [CNT_W-1:0]  group_reg, group_next;
    logic              ovf_reg, ovf_next;
    logic              last_reg, last_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  issue_reg, issue_next;
    logic              va_reg, va_next;
    logic              vb_reg, vb_next;
    logic              vc_reg, vc_next;
    logic              have_reg, have_next;
    logic [IDX_W-1:0]  rel_reg, rel_next;
    logic              wv_reg, wv_next;
    logic [IDX_W-1:0]  out_ptr_reg, out_ptr_next;
    logic              m_valid_reg, m_valid_next;

    // Payload registers.
    logic [COORD_W-1:0]   x_new_reg, y_new_reg;
    logic [RAD_W-1:0]     r_new_reg;
    logic [IDX_W-1:0]     cur_reg, hi_reg, lo_reg;
    logic [IDX_W-1:0]     ja_reg, jb_reg, jc_reg, widx_reg;
    logic [DX_W-1:0]      dx_reg, dy_reg;
    logic [TD_W-1:0]      td_reg;
    logic [IDX_W-1:0]     lbl_b_reg, lbl_c_reg;
    logic [SQ_W-1:0]      dx2_reg, dy2_reg;
    logic [TD2_W-1:0]     td2_reg;
    logic [OUT_IDX_W-1:0] m_idx_reg;
    logic [OUT_LBL_W-1:0] m_lbl_reg;
    logic [OUT_CNT_W-1:0] m_live_reg, m_used_reg;
    logic                 m_ovf_reg, m_last_reg;

    // Memory ports.
    logic             xyr_we;
    logic [XYR_W-1:0] xyr_rdata;
    logic             lbl_we;
    logic [IDX_W-1:0] lbl_waddr, lbl_wdata, lbl_raddr, lbl_rdata;

    // Compare and arithmetic signals.
    logic [COORD_W-1:0]      x_j, y_j;
    logic [RAD_W-1:0]        r_j;
    logic [DX_W-1:0]         dx_b, dy_b;
    logic [TD_W-1:0]         td_b;
    logic signed [2*DX_W-1:0] dx2_full, dy2_full;
    logic [TD2_W-1:0]        td2_full;
    logic [D2_W-1:0]         d2;
    logic                    linked, cmp_link, merge, take, full, out_last;
    logic [IDX_W-1:0]        merge_hi, merge_lo, final_lbl;

    assign full     = (count_reg == CNT_W'(MAX_POINTS));
    assign out_last = ((CNT_W'(out_ptr_reg) + 1'b1) == count_reg);

    // Point coordinates and radius, one entry per stored point.
    assign xyr_we = cmd.accept && !full;

    pcd_ram #(.WIDTH(XYR_W), .DEPTH(MAX_POINTS)) u_xyr_ram (
        .aclk  (aclk),
        .we    (xyr_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (s_tdata[XYR_W-1:0]),
        .raddr (issue_reg),
        .rdata (xyr_rdata)
    );

    // Cluster label of each stored point.
    assign final_lbl = have_reg ? cur_reg : lbl_cnt_reg[IDX_W-1:0];
    assign lbl_we    = cmd.finish || (wv_reg && (lbl_rdata == hi_reg));
    assign lbl_waddr = cmd.finish ? i_reg : widx_reg;
    assign lbl_wdata = cmd.finish ? final_lbl : lo_reg;
    assign lbl_raddr = cmd.rel_step  ? rel_reg :
                       cmd.out_issue ? out_ptr_reg : issue_reg;

    pcd_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_lbl_ram (
        .aclk  (aclk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .raddr (lbl_raddr),
        .rdata (lbl_rdata)
    );

    // Stage B: differences and link distance from the stored entry.
    assign x_j  = xyr_rdata[COORD_W-1:0];
    assign y_j  = xyr_rdata[2*COORD_W-1:COORD_W];
    assign r_j  = xyr_rdata[XYR_W-1:2*COORD_W];
    assign dx_b = {x_new_reg[COORD_W-1], x_new_reg} - {x_j[COORD_W-1], x_j};
    assign dy_b = {y_new_reg[COORD_W-1], y_new_reg} - {y_j[COORD_W-1], y_j};
    assign td_b = use_radii_reg ?
                  (TD_W'(link_dist_reg) + TD_W'(r_new_reg) + TD_W'(r_j)) :
                  TD_W'(link_dist_reg);

    // Stage C: squares.
    assign dx2_full = $signed(dx_reg) * $signed(dx_reg);
    assign dy2_full = $signed(dy_reg) * $signed(dy_reg);
    assign td2_full = td_reg * td_reg;

    // Compare stage.
    assign d2       = D2_W'(dx2_reg) + D2_W'(dy2_reg);
    assign linked   = (TD2_W'(d2) <= td2_reg);
    assign cmp_link = vc_reg && linked && !(have_reg && (lbl_c_reg == cur_reg));
    assign merge    = cmp_link && have_reg;
    assign take     = cmp_link && !have_reg;
    assign merge_hi = (cur_reg > lbl_c_reg) ? cur_reg : lbl_c_reg;
    assign merge_lo = (cur_reg > lbl_c_reg) ? lbl_c_reg : cur_reg;

    always_comb begin
        link_dist_next = link_dist_reg;
        use_radii_next = use_radii_reg;
        count_next     = count_reg;
        lbl_cnt_next   = lbl_cnt_reg;
        group_next     = group_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        i_next         = i_reg;
        issue_next     = issue_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        vc_next        = vc_reg;
        have_next      = have_reg;
        rel_next       = rel_reg;
        wv_next        = wv_reg;
        out_ptr_next   = out_ptr_reg;
        m_valid_next   = m_valid_reg;

        if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_LINK_DISTANCE: link_dist_next = cfg_wdata[DIST_W-1:0];
                REG_USE_RADII:     use_radii_next = cfg_wdata[0];
                default: ;
            endcase
        end

        if (cmd.accept) begin
            last_next = s_tlast;
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                i_next     = count_reg[IDX_W-1:0];
                count_next = count_reg + 1'b1;
                have_next  = 1'b0;
                issue_next = '0;
            end
        end

        if (cmd.scan_step) begin
            if (merge) begin
                va_next    = 1'b0;
                vb_next    = 1'b0;
                vc_next    = 1'b0;
                issue_next = jc_reg + 1'b1;
                group_next = group_reg - 1'b1;
                rel_next   = '0;
                wv_next    = 1'b0;
            end else begin
                if (take) begin
                    have_next = 1'b1;
                end
                vb_next = va_reg;
                vc_next = vb_reg;
                if (issue_reg != i_reg) begin
                    va_next    = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end else begin
                    va_next = 1'b0;
                end
            end
        end

        if (cmd.rel_step) begin
            if (rel_reg != i_reg) begin
                rel_next = rel_reg + 1'b1;
                wv_next  = 1'b1;
            end else begin
                wv_next = 1'b0;
            end
        end

        if (cmd.finish && !have_reg) begin
            lbl_cnt_next = lbl_cnt_reg + 1'b1;
            group_next   = group_reg + 1'b1;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            if (out_last) begin
                out_ptr_next = '0;
                count_next   = '0;
                lbl_cnt_next = '0;
                group_next   = '0;
                ovf_next     = 1'b0;
            end else begin
                out_ptr_next = out_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_dist_reg <= LINK_DISTANCE_RESET;
            use_radii_reg <= 1'b1;
            count_reg     <= '0;
            lbl_cnt_reg   <= '0;
            group_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            i_reg         <= '0;
            issue_reg     <= '0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            have_reg      <= 1'b0;
            rel_reg       <= '0;
            wv_reg        <= 1'b0;
            out_ptr_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            link_dist_reg <= link_dist_next;
            use_radii_reg <= use_radii_next;
            count_reg     <= count_next;
            lbl_cnt_reg   <= lbl_cnt_next;
            group_reg     <= group_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            i_reg         <= i_next;
            issue_reg     <= issue_next;
            va_reg        <= va_next;
            vb_reg        <= vb_next;
            vc_reg        <= vc_next;
            have_reg      <= have_next;
            rel_reg       <= rel_next;
            wv_reg        <= wv_next;
            out_ptr_reg   <= out_ptr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // The compare pipeline runs freely; the valid bits above decide what counts.
    always_ff @(posedge aclk) begin
        ja_reg    <= issue_reg;
        jb_reg    <= ja_reg;
        jc_reg    <= jb_reg;
        dx_reg    <= dx_b;
        dy_reg    <= dy_b;
        td_reg    <= td_b;
        lbl_b_reg <= lbl_rdata;
        lbl_c_reg <= lbl_b_reg;
        dx2_reg   <= dx2_full[SQ_W-1:0];
        dy2_reg   <= dy2_full[SQ_W-1:0];
        td2_reg   <= td2_full;

        if (xyr_we) begin
            x_new_reg <= s_tdata[COORD_W-1:0];
            y_new_reg <= s_tdata[2*COORD_W-1:COORD_W];
            r_new_reg <= s_tdata[XYR_W-1:2*COORD_W];
        end
        if (cmd.scan_step && merge) begin
            hi_reg  <= merge_hi;
            lo_reg  <= merge_lo;
            cur_reg <= merge_lo;
        end else if (cmd.scan_step && take) begin
            cur_reg <= lbl_c_reg;
        end
        if (cmd.rel_step) begin
            widx_reg <= rel_reg;
        end
        if (cmd.out_load) begin
            m_idx_reg  <= OUT_IDX_W'(out_ptr_reg);
            m_lbl_reg  <= OUT_LBL_W'(lbl_rdata);
            m_live_reg <= OUT_CNT_W'(group_reg);
            m_used_reg <= OUT_CNT_W'(lbl_cnt_reg);
            m_ovf_reg  <= ovf_reg;
            m_last_reg <= out_last;
        end
    end

    assign sts.full      = full;
    assign sts.merge     = merge;
    assign sts.scan_done = (issue_reg == i_reg) && !va_reg && !vb_reg && !vc_reg;
    assign sts.rel_done  = (rel_reg == i_reg) && !wv_reg;
    assign sts.last      = last_reg;
    assign sts.out_busy  = m_valid_reg;
    assign sts.out_last  = out_last;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - M_USED_W)'(0), m_used_reg, m_live_reg, m_lbl_reg, m_idx_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;

endmodule

// ===== sv/point_cluster_by_distance.sv =====
// Distance-threshold clustering of 2-D points (single linkage).
// Input channel (s_): one word per point, x and y as signed fixed point and
// a radius, all with 4 fraction bits; s_tlast marks the final point of a set.
// Output channel (m_): after the final point, one word per stored point in
// arrival order with its cluster label, the live and issued group counts in
// every word, the overflow flag in m_tuser, and m_tlast on the final word.
// Configuration: link_distance (index 0) and use_radii (index 1) through the
// plain write port, written by the user while the block is idle (no check).
// Each point is compared with every earlier stored point by the four-stage
// compare pipeline, which reads one stored point per cycle until a merge
// halts it. Each merge of two labels adds a relabel sweep, one stored label
// per cycle, then a refill of the compare pipeline. Readout loads a word
// only after the receiver has taken the previous one; a stalled receiver
// holds the word in the output register and the readout waits.
// The next point is taken as soon as the last word is loaded.
// A point arriving with the store full is dropped and flags overflow.
// Reset clears the counters and restores link_distance to 16 (1.0) and
// use_radii to 1; the point stores themselves are not cleared.
`include "point_cluster_by_distance_defines.svh"

module point_cluster_by_distance import pcd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Point input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // x_pos[15:0], y_pos[31:16], radius[47:32]
    input  logic                  s_tlast,  // last_point
    // Label output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,  // point_index[5:0], label[11:6],
                                            // live_groups[18:12], labels_used[25:19]
    output logic                  m_tlast,  // end_of_list
    output logic                  m_tuser   // overflow
);

    pcd_cmd_t cmd;
    pcd_sts_t sts;

    // Sequencer: accept, compare scan, relabel sweeps, label settle, readout.
    pcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Point and label memories, distance arithmetic, counters, output register.
    pcd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The controller issues at most one datapath command per cycle.
    `PCD_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command")
    // A readout word is never loaded over a word the receiver has not taken.
    `PCD_ASSERT_NOW(a_no_overwrite, cmd.out_load, !m_tvalid, "output word overwritten")
    // The final word of a readout is not followed at once by another word.
    `PCD_ASSERT_NEXT(a_gap_after_last, m_tvalid && m_tready && m_tlast, !m_tvalid, "no idle cycle")
    // New points are taken only with the compare pipeline drained.
    `PCD_ASSERT_NOW(a_idle_drained, s_tready, sts.scan_done, "input ready while busy")

endmodule
